[hw/rtl/stc_pkg.sv]
// stc_pkg: shared types, constants and arithmetic helpers for the trim compensation block
// no dependencies
`default_nettype none
package stc_pkg;

  localparam int FINE_LAT  = 4;
  localparam int FRONT_LAT = 10;
  localparam int HUM_LAT   = 9;
  localparam int DIV_LAT   = 32;
  localparam int POST_LAT  = 4;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + POST_LAT;

  localparam logic [2:0] REG_TEMP_TRIM   = 3'd0;
  localparam logic [2:0] REG_PRESS_A     = 3'd1;
  localparam logic [2:0] REG_PRESS_B     = 3'd2;
  localparam logic [2:0] REG_PRESS_LAST  = 3'd3;
  localparam logic [2:0] REG_HUM_A       = 3'd4;
  localparam logic [2:0] REG_HUM_B       = 3'd5;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_q10;
  } result_t;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } trim_t;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        big;
    logic        zero;
  } div_req_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = $signed(x) >>> n;
    return s;
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/stc_delay.sv]
// stc_delay: fixed-length register shift line for aligning results
// no dependencies
`default_nettype none
module stc_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

[hw/rtl/stc_front.sv]
// stc_front: fine temperature, temperature and pressure divider operands
// depends on stc_pkg
`default_nettype none
module stc_front (
  input  wire logic             clk,
  input  wire stc_pkg::item_t   item,
  input  wire stc_pkg::trim_t   trim,
  output logic [31:0]           fine,
  output logic [15:0]           hum_raw,
  output logic [31:0]           temp,
  output stc_pkg::div_req_t     req
);

  logic [31:0] u1, d1, m12, dd2, a3, m33, fine4, temp5, pa5, pd5;
  logic [31:0] pdd6, ma56, ma26, temp6, b17, c37, ma57, ma27, temp7;
  logic [31:0] b8, a8, temp8, n9, dm9, temp9, temp10;
  logic [19:0] ap1, ap2, ap3, ap4, ap5, ap6, ap7, ap8;
  logic [15:0] ah1, ah2, ah3, ah4;
  logic [31:0] at, half, den;
  stc_pkg::div_req_t req10;

  assign at   = {12'd0, item.raw_temperature};
  assign half = stc_pkg::asr(fine4, 1) - 32'd64000;
  assign den  = stc_pkg::asr(dm9, 15);

  always_ff @(posedge clk) begin
    u1    <= (at >> 3) - (trim.t1 << 1);
    d1    <= (at >> 4) - trim.t1;
    ap1   <= item.raw_pressure;
    ah1   <= item.raw_humidity;

    m12   <= stc_pkg::mul(u1, trim.t2);
    dd2   <= stc_pkg::mul(d1, d1);
    ap2   <= ap1;
    ah2   <= ah1;

    a3    <= stc_pkg::asr(m12, 11);
    m33   <= stc_pkg::mul(stc_pkg::asr(dd2, 12), trim.t3);
    ap3   <= ap2;
    ah3   <= ah2;

    fine4 <= a3 + stc_pkg::asr(m33, 14);
    ap4   <= ap3;
    ah4   <= ah3;

    temp5 <= stc_pkg::asr((fine4 << 2) + fine4 + 32'd128, 8);
    pa5   <= half;
    pd5   <= stc_pkg::asr(half, 2);
    ap5   <= ap4;

    pdd6  <= stc_pkg::mul(pd5, pd5);
    ma56  <= stc_pkg::mul(pa5, trim.p5);
    ma26  <= stc_pkg::mul(trim.p2, pa5);
    temp6 <= temp5;
    ap6   <= ap5;

    b17   <= stc_pkg::mul(stc_pkg::asr(pdd6, 11), trim.p6);
    c37   <= stc_pkg::mul(trim.p3, stc_pkg::asr(pdd6, 13));
    ma57  <= ma56;
    ma27  <= ma26;
    temp7 <= temp6;
    ap7   <= ap6;

    b8    <= stc_pkg::asr(b17 + (ma57 << 1), 2) + (trim.p4 << 16);
    a8    <= stc_pkg::asr(stc_pkg::asr(c37, 3) + stc_pkg::asr(ma27, 1), 18);
    temp8 <= temp7;
    ap8   <= ap7;

    n9    <= stc_pkg::mul((32'd1048576 - {12'd0, ap8}) - stc_pkg::asr(b8, 12), 32'd3125);
    dm9   <= stc_pkg::mul(32'd32768 + a8, trim.p1);
    temp9 <= temp8;

    req10.dividend <= n9[31] ? n9 : (n9 << 1);
    req10.divisor  <= den;
    req10.big      <= n9[31];
    req10.zero     <= (den == 32'd0);
    temp10         <= temp9;
  end

  assign fine    = fine4;
  assign hum_raw = ah4;
  assign temp    = temp10;
  assign req     = req10;

endmodule
`default_nettype wire

[hw/rtl/stc_hum.sv]
// stc_hum: humidity compensation pipeline from fine temperature
// depends on stc_pkg
`default_nettype none
module stc_hum (
  input  wire logic           clk,
  input  wire logic [31:0]    fine,
  input  wire logic [15:0]    hum_raw,
  input  wire stc_pkg::trim_t trim,
  output logic [16:0]         hum
);

  logic [31:0] v, xa1, mv5, mv6, mv3, x2, y02, yk2, y13, x3, y24, x4, y5, x5;
  logic [31:0] v6, dd7, v7, m8, v8, dv, vc;
  logic [16:0] hum9;

  assign v  = fine - 32'd76800;
  assign dv = v8 - stc_pkg::asr(m8, 4);

  always_comb begin
    if (dv[31]) begin
      vc = 32'd0;
    end else if (dv > stc_pkg::HUM_MAX) begin
      vc = stc_pkg::HUM_MAX;
    end else begin
      vc = dv;
    end
  end

  always_ff @(posedge clk) begin
    xa1  <= ({16'd0, hum_raw} << 14) - (trim.h4 << 20);
    mv5  <= stc_pkg::mul(trim.h5, v);
    mv6  <= stc_pkg::mul(v, trim.h6);
    mv3  <= stc_pkg::mul(v, trim.h3);

    x2   <= stc_pkg::asr(xa1 - mv5 + 32'd16384, 15);
    y02  <= stc_pkg::asr(mv6, 10);
    yk2  <= stc_pkg::asr(mv3, 11) + 32'd32768;

    y13  <= stc_pkg::mul(y02, yk2);
    x3   <= x2;

    y24  <= stc_pkg::mul(stc_pkg::asr(y13, 10) + 32'd2097152, trim.h2);
    x4   <= x3;

    y5   <= stc_pkg::asr(y24 + 32'd8192, 14);
    x5   <= x4;

    v6   <= stc_pkg::mul(x5, y5);

    dd7  <= stc_pkg::mul(stc_pkg::asr(v6, 15), stc_pkg::asr(v6, 15));
    v7   <= v6;

    m8   <= stc_pkg::mul(stc_pkg::asr(dd7, 7), trim.h1);
    v8   <= v7;

    hum9 <= vc[28:12];
  end

  assign hum = hum9;

endmodule
`default_nettype wire

[hw/rtl/stc_div.sv]
// stc_div: pipelined restoring divider, one quotient bit per stage
// depends on stc_pkg
`default_nettype none
module stc_div (
  input  wire logic              clk,
  input  wire stc_pkg::div_req_t req,
  output logic [31:0]            quo,
  output logic                   big,
  output logic                   zero
);

  localparam int N = stc_pkg::DIV_LAT;

  logic [31:0] rem_r [N];
  logic [31:0] quo_r [N];
  logic [31:0] dvd_r [N];
  logic [31:0] dsr_r [N];
  logic        big_r [N];
  logic        zro_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0] s_rem, s_quo, s_dvd, s_dsr;
    logic        s_big, s_zro;
    logic [32:0] trial, diff;

    if (k == 0) begin : g_first
      assign s_rem = 32'd0;
      assign s_quo = 32'd0;
      assign s_dvd = req.dividend;
      assign s_dsr = req.divisor;
      assign s_big = req.big;
      assign s_zro = req.zero;
    end else begin : g_next
      assign s_rem = rem_r[k-1];
      assign s_quo = quo_r[k-1];
      assign s_dvd = dvd_r[k-1];
      assign s_dsr = dsr_r[k-1];
      assign s_big = big_r[k-1];
      assign s_zro = zro_r[k-1];
    end

    assign trial = {s_rem, s_dvd[31]};
    assign diff  = trial - {1'b0, s_dsr};

    always_ff @(posedge clk) begin
      if (!diff[32]) begin
        rem_r[k] <= diff[31:0];
        quo_r[k] <= {s_quo[30:0], 1'b1};
      end else begin
        rem_r[k] <= trial[31:0];
        quo_r[k] <= {s_quo[30:0], 1'b0};
      end
      dvd_r[k] <= s_dvd << 1;
      dsr_r[k] <= s_dsr;
      big_r[k] <= s_big;
      zro_r[k] <= s_zro;
    end
  end

  assign quo  = quo_r[N-1];
  assign big  = big_r[N-1];
  assign zero = zro_r[N-1];

endmodule
`default_nettype wire

[hw/rtl/stc_post.sv]
// stc_post: pressure correction after the divide
// depends on stc_pkg
`default_nettype none
module stc_post (
  input  wire logic           clk,
  input  wire logic [31:0]    quo,
  input  wire logic           big,
  input  wire logic           zero,
  input  wire stc_pkg::trim_t trim,
  output logic [31:0]         pres
);

  logic [31:0] pres1, pres2, pres3, x2, m82, ma3, b3, pres4;
  logic        zero1, zero2, zero3;

  always_ff @(posedge clk) begin
    pres1 <= big ? (quo << 1) : quo;
    zero1 <= zero;

    x2    <= stc_pkg::mul(pres1 >> 3, pres1 >> 3);
    m82   <= stc_pkg::mul(pres1 >> 2, trim.p8);
    pres2 <= pres1;
    zero2 <= zero1;

    ma3   <= stc_pkg::mul(trim.p9, x2 >> 13);
    b3    <= stc_pkg::asr(m82, 13);
    pres3 <= pres2;
    zero3 <= zero2;

    pres4 <= zero3 ? 32'd0
                   : pres3 + stc_pkg::asr(stc_pkg::asr(ma3, 12) + b3 + trim.p7, 4);
  end

  assign pres = pres4;

endmodule
`default_nettype wire

[hw/rtl/sensor_trim_compensation.sv]
// sensor_trim_compensation: top level, trim registers, valid chain and result alignment
// depends on stc_pkg, stc_front, stc_hum, stc_div, stc_post, stc_delay
//
// one reading set is taken every clock cycle; busy never rises. each result appears on
// result for one cycle with done high after its start transfer; the latency is set
// mostly by the 32-stage pipelined pressure divider. the receiver cannot stall the
// output. trim registers sit on the apb port at 8-byte steps and must be written only
// while no reading is in flight; the block itself does not enforce this.
`default_nettype none
module sensor_trim_compensation (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire stc_pkg::item_t   item,
  output logic                  done,
  output stc_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [5:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int LAT = stc_pkg::TOTAL_LAT;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_a, press_trim_b;
  logic [15:0] press_trim_last;
  logic [39:0] hum_trim_a;
  logic [31:0] hum_trim_b;
  logic [LAT-1:0] vld;
  logic [2:0] idx;
  logic wr;
  stc_pkg::trim_t trim;
  stc_pkg::div_req_t req;
  logic [31:0] fine, temp, temp_d, quo, pres;
  logic [15:0] hum_raw;
  logic [16:0] hum, hum_d;
  logic big, zero;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_a    <= '0;
      press_trim_b    <= '0;
      press_trim_last <= '0;
      hum_trim_a      <= '0;
      hum_trim_b      <= '0;
    end else if (wr) begin
      case (idx)
        stc_pkg::REG_TEMP_TRIM:  temp_trim       <= pwdata[47:0];
        stc_pkg::REG_PRESS_A:    press_trim_a    <= pwdata;
        stc_pkg::REG_PRESS_B:    press_trim_b    <= pwdata;
        stc_pkg::REG_PRESS_LAST: press_trim_last <= pwdata[15:0];
        stc_pkg::REG_HUM_A:      hum_trim_a      <= pwdata[39:0];
        stc_pkg::REG_HUM_B:      hum_trim_b      <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      stc_pkg::REG_TEMP_TRIM:  prdata = {16'd0, temp_trim};
      stc_pkg::REG_PRESS_A:    prdata = press_trim_a;
      stc_pkg::REG_PRESS_B:    prdata = press_trim_b;
      stc_pkg::REG_PRESS_LAST: prdata = {48'd0, press_trim_last};
      stc_pkg::REG_HUM_A:      prdata = {24'd0, hum_trim_a};
      stc_pkg::REG_HUM_B:      prdata = {32'd0, hum_trim_b};
      default:                 prdata = 64'd0;
    endcase
  end

  always_comb begin
    trim.t1 = {16'd0, temp_trim[15:0]};
    trim.t2 = stc_pkg::sx16(temp_trim[31:16]);
    trim.t3 = stc_pkg::sx16(temp_trim[47:32]);
    trim.p1 = {16'd0, press_trim_a[15:0]};
    trim.p2 = stc_pkg::sx16(press_trim_a[31:16]);
    trim.p3 = stc_pkg::sx16(press_trim_a[47:32]);
    trim.p4 = stc_pkg::sx16(press_trim_a[63:48]);
    trim.p5 = stc_pkg::sx16(press_trim_b[15:0]);
    trim.p6 = stc_pkg::sx16(press_trim_b[31:16]);
    trim.p7 = stc_pkg::sx16(press_trim_b[47:32]);
    trim.p8 = stc_pkg::sx16(press_trim_b[63:48]);
    trim.p9 = stc_pkg::sx16(press_trim_last);
    trim.h1 = {24'd0, hum_trim_a[7:0]};
    trim.h2 = stc_pkg::sx16(hum_trim_a[23:8]);
    trim.h3 = {24'd0, hum_trim_a[31:24]};
    trim.h6 = {{24{hum_trim_a[39]}}, hum_trim_a[39:32]};
    trim.h4 = stc_pkg::sx16(hum_trim_b[15:0]);
    trim.h5 = stc_pkg::sx16(hum_trim_b[31:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  stc_front u_front (
    .clk(clk), .item(item), .trim(trim),
    .fine(fine), .hum_raw(hum_raw), .temp(temp), .req(req)
  );

  stc_hum u_hum (
    .clk(clk), .fine(fine), .hum_raw(hum_raw), .trim(trim), .hum(hum)
  );

  stc_div u_div (
    .clk(clk), .req(req), .quo(quo), .big(big), .zero(zero)
  );

  stc_post u_post (
    .clk(clk), .quo(quo), .big(big), .zero(zero), .trim(trim), .pres(pres)
  );

  stc_delay #(.WIDTH(32), .DEPTH(LAT - stc_pkg::FRONT_LAT)) u_temp_dly (
    .clk(clk), .din(temp), .dout(temp_d)
  );

  stc_delay #(.WIDTH(17), .DEPTH(LAT - stc_pkg::FINE_LAT - stc_pkg::HUM_LAT)) u_hum_dly (
    .clk(clk), .din(hum), .dout(hum_d)
  );

  assign done                     = vld[LAT-1];
  assign result.temperature_centi = $signed(temp_d);
  assign result.pressure_pa       = pres;
  assign result.humidity_q10      = hum_d;

endmodule
`default_nettype wire
